[hw/rtl/url_percent_decoder_defines.svh]
// Assertion helpers for the decoder; all sample on clk and are disabled while rst_n is low.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Same-cycle implication.
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/upd_pkg.sv]
package upd_pkg;

  localparam logic [7:0] PCT_CHAR       = 8'h25;
  localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_PCT    = 2'd1,
    PH_DIGIT  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] nibble;
    logic [7:0] digit_char;
  } upd_state_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] dat;
    logic [2:0]      last;
  } upd_res_t;

endpackage

[hw/rtl/upd_stream_if.sv]
interface upd_in_if;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output in_valid, output in_byte, output in_last, input in_ready);
  modport sink (input in_valid, input in_byte, input in_last, output in_ready);
endinterface

interface upd_out_if;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output out_valid, output out_byte, output out_last, input out_ready);
  modport sink (input out_valid, input out_byte, input out_last, output out_ready);
endinterface

[hw/rtl/upd_step.sv]
module upd_step (
  input  upd_pkg::upd_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output upd_pkg::upd_state_t st_nxt,
  output upd_pkg::upd_res_t   res
);
  import upd_pkg::*;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41) begin
      v = (c & CASE_FOLD_MASK) - 8'h37;
    end else begin
      v = c - 8'h30;
    end
    return v[3:0];
  endfunction

  always_comb begin
    logic [1:0] n;
    logic       do_plain;
    logic       hex;
    n        = 2'd0;
    do_plain = 1'b0;
    hex      = is_hex(in_byte);
    st_nxt   = st;
    res      = '0;
    unique case (st.phase)
      PH_PCT: begin
        if (hex) begin
          st_nxt.nibble     = hex_value(in_byte);
          st_nxt.digit_char = in_byte;
          st_nxt.phase      = PH_DIGIT;
        end else begin
          res.dat[n] = PCT_CHAR;
          n          = n + 2'd1;
          do_plain   = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          res.dat[n]   = {st.nibble, hex_value(in_byte)};
          n            = n + 2'd1;
          st_nxt.phase = PH_NORMAL;
        end else begin
          res.dat[n] = PCT_CHAR;
          n          = n + 2'd1;
          res.dat[n] = st.digit_char;
          n          = n + 2'd1;
          do_plain   = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase
    if (do_plain) begin
      if (in_byte == PCT_CHAR) begin
        st_nxt.phase = PH_PCT;
      end else begin
        st_nxt.phase = PH_NORMAL;
        res.dat[n]   = in_byte;
        n            = n + 2'd1;
      end
    end
    // flush a pending escape on the final beat
    if (in_last) begin
      if (st_nxt.phase == PH_PCT) begin
        res.dat[n] = PCT_CHAR;
        n          = n + 2'd1;
      end else if (st_nxt.phase == PH_DIGIT) begin
        res.dat[n] = PCT_CHAR;
        n          = n + 2'd1;
        res.dat[n] = st_nxt.digit_char;
        n          = n + 2'd1;
      end
      st_nxt.phase = PH_NORMAL;
      if (n != 2'd0) begin
        res.last[n - 2'd1] = 1'b1;
      end
    end
    res.cnt = n;
  end

endmodule

[hw/rtl/url_percent_decoder.sv]
// URL percent decoder. Each input beat carries one raw byte and a last mark;
// "%hh" (either case) becomes one byte, a malformed or truncated escape passes
// through as written, and the last beat flushes a pending escape and resets the
// escape state. Results land in a 4-entry output queue in the cycle after the
// beat is accepted. The input takes one beat per cycle while the queue holds at
// most one result (or two with one leaving); a beat yields zero to three results,
// and the output drains one per cycle while out_ready is high, so malformed
// escapes can stall the input.
`include "url_percent_decoder_defines.svh"

module url_percent_decoder (
  input logic      clk,
  input logic      rst_n,
  upd_in_if.sink   in_ch,
  upd_out_if.source out_ch
);
  import upd_pkg::*;

  localparam int QDEPTH = 4;

  upd_state_t st_r, st_nxt;
  upd_res_t   res;

  logic [QDEPTH-1:0][7:0] q_dat_r, q_dat_nxt;
  logic [QDEPTH-1:0]      q_last_r, q_last_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [2:0]             cnt_take;
  logic                   in_fire, out_fire;

  upd_step u_step (
    .st      (st_r),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign in_ch.in_ready   = (cnt_r <= 3'd1) || (cnt_r == 3'd2 && out_ch.out_ready);
  assign in_fire          = in_ch.in_valid && in_ch.in_ready;
  assign out_ch.out_valid = (cnt_r != 3'd0);
  assign out_fire         = out_ch.out_valid && out_ch.out_ready;
  assign out_ch.out_byte  = q_dat_r[0];
  assign out_ch.out_last  = q_last_r[0];

  assign cnt_take = cnt_r - {2'b00, out_fire};

  always_comb begin
    logic [1:0] idx;
    q_dat_nxt  = q_dat_r;
    q_last_nxt = q_last_r;
    cnt_nxt    = cnt_take;
    idx        = '0;
    // advance the queue head
    if (out_fire) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_dat_nxt[i]  = q_dat_r[i+1];
        q_last_nxt[i] = q_last_r[i+1];
      end
    end
    // append this beat's results behind what remains
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < res.cnt) begin
          idx             = cnt_take[1:0] + 2'(i);
          q_dat_nxt[idx]  = res.dat[i];
          q_last_nxt[idx] = res.last[i];
        end
      end
      cnt_nxt = cnt_take + {1'b0, res.cnt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      st_r  <= '{phase: PH_NORMAL, nibble: 4'd0, digit_char: 8'd0};
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        st_r <= st_nxt;
      end
    end
    q_dat_r  <= q_dat_nxt;
    q_last_r <= q_last_nxt;
  end

  `UPD_ASSERT_NOW(a_queue_bound, 1'b1, cnt_r <= 3'(QDEPTH), "output queue overrun")
  `UPD_ASSERT_NOW(a_room_on_accept, in_fire, cnt_take <= 3'd1, "beat accepted without room")
  `UPD_ASSERT_NEXT(a_last_clears_phase, in_fire && in_ch.in_last, st_r.phase == PH_NORMAL,
    "escape state survived last beat")
  `UPD_ASSERT_NEXT(a_empty_stays, cnt_r == 3'd0 && !in_fire, cnt_r == 3'd0,
    "queue filled without a beat")

endmodule

[tb/url_percent_decoder_tb.sv]
module url_percent_decoder_tb;
  import upd_pkg::*;

  localparam int RAND_ITEMS = 436;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [7:0] val;
    logic       fin;
  } dec_byte_t;

  typedef struct packed {
    logic [7:0]      raw;
    logic            mark;
    logic            fixed;
    logic [1:0]      cnt;
    logic [0:2][7:0] eb;
    logic [0:2]      el;
  } dir_row_t;

  localparam int N_DIR = 24;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{8'h41, 1'b0, 1'b1, 2'd1, {8'h41, 8'h00, 8'h00}, 3'b000},
    '{8'h00, 1'b0, 1'b1, 2'd1, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'hFF, 1'b1, 1'b1, 2'd1, {8'hFF, 8'h00, 8'h00}, 3'b100},
    '{8'h25, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h34, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h31, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h25, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h66, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h46, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h25, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    // bad first digit
    '{8'h67, 1'b0, 1'b1, 2'd2, {8'h25, 8'h67, 8'h00}, 3'b000},
    '{8'h25, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    // percent as bad first digit, starts a new escape
    '{8'h25, 1'b0, 1'b1, 2'd1, {8'h25, 8'h00, 8'h00}, 3'b000},
    '{8'h61, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h42, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h25, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h33, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    // bad second digit
    '{8'h7A, 1'b0, 1'b1, 2'd3, {8'h25, 8'h33, 8'h7A}, 3'b000},
    '{8'h25, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h37, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    // bad second digit, then truncated escape at the last byte
    '{8'h25, 1'b1, 1'b1, 2'd3, {8'h25, 8'h37, 8'h25}, 3'b001},
    '{8'h25, 1'b1, 1'b1, 2'd1, {8'h25, 8'h00, 8'h00}, 3'b100},
    '{8'h25, 1'b0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 3'b000},
    '{8'h39, 1'b1, 1'b1, 2'd2, {8'h25, 8'h39, 8'h00}, 3'b010}
  };

  localparam logic [7:0] NEAR_HEX [13] = '{
    8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h46,
    8'h47, 8'h60, 8'h61, 8'h66, 8'h67, 8'h25
  };

  logic clk = 1'b0;
  logic rst_n;

  upd_in_if  in_ch();
  upd_out_if out_ch();

  url_percent_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  dec_byte_t  decoded_due [$];
  dec_byte_t  beat_res [$];
  dec_byte_t  want;
  phase_t     dec_phase = PH_NORMAL;
  logic [3:0] dec_nib = 4'h0;
  logic [7:0] dec_held = 8'h00;
  int         mismatches = 0;
  bit         feed_rush = 1'b0;
  bit         drain_rush = 1'b0;
  int         stall_left = 0;

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = (c >= 8'h41) ? (c & CASE_FOLD_MASK) - 8'h37 : c - 8'h30;
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + v;
    return (upper ? 8'h37 : 8'h57) + v;
  endfunction

  function automatic void take_plain(input logic [7:0] raw);
    if (raw == PCT_CHAR) begin
      dec_phase = PH_PCT;
    end else begin
      dec_phase = PH_NORMAL;
      beat_res.push_back('{raw, 1'b0});
    end
  endfunction

  // Work out the decoded bytes one raw byte yields; leaves them in beat_res.
  function automatic void decode_beat(input logic [7:0] raw, input logic mark);
    beat_res.delete();
    unique case (dec_phase)
      PH_PCT: begin
        if (is_hex(raw)) begin
          dec_nib = hex_nib(raw);
          dec_held = raw;
          dec_phase = PH_DIGIT;
        end else begin
          beat_res.push_back('{PCT_CHAR, 1'b0});
          take_plain(raw);
        end
      end
      PH_DIGIT: begin
        if (is_hex(raw)) begin
          beat_res.push_back('{{dec_nib, hex_nib(raw)}, 1'b0});
          dec_phase = PH_NORMAL;
        end else begin
          beat_res.push_back('{PCT_CHAR, 1'b0});
          beat_res.push_back('{dec_held, 1'b0});
          take_plain(raw);
        end
      end
      default: take_plain(raw);
    endcase
    if (mark) begin
      if (dec_phase == PH_PCT) begin
        beat_res.push_back('{PCT_CHAR, 1'b0});
      end else if (dec_phase == PH_DIGIT) begin
        beat_res.push_back('{PCT_CHAR, 1'b0});
        beat_res.push_back('{dec_held, 1'b0});
      end
      dec_phase = PH_NORMAL;
      if (beat_res.size() > 0) beat_res[beat_res.size() - 1].fin = 1'b1;
    end
  endfunction

  // Enter and leave at a falling edge; hold valid across back-to-back beats.
  task automatic send_beat(input logic [7:0] raw, input logic mark);
    int gap;
    gap = feed_rush ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.in_valid <= 1'b1;
    in_ch.in_byte <= raw;
    in_ch.in_last <= mark;
    do @(posedge clk); while (!in_ch.in_ready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) drain_rush <= ($urandom_range(0, 2) == 0);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.out_ready <= 1'b0;
    end else if (!drain_rush && $urandom_range(0, 2) == 0) begin
      stall_left <= pick_gap();
      out_ch.out_ready <= 1'b0;
    end else begin
      out_ch.out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.out_valid && out_ch.out_ready) begin
      if (decoded_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte=%h last=%b",
                 $time, out_ch.out_byte, out_ch.out_last);
        mismatches++;
      end else begin
        want = decoded_due.pop_front();
        if (out_ch.out_byte !== want.val) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.val, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.out_last !== want.fin) begin
          $display("%0t: out_last expected %b actual %b", $time, want.fin, out_ch.out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [7:0] text [$];
    int         fed;
    int         chunks;
    int         pick;
    rst_n = 1'b0;
    in_ch.in_valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.out_ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_beat(DIRECTED[i].raw, DIRECTED[i].mark);
      decode_beat(DIRECTED[i].raw, DIRECTED[i].mark);
      if (DIRECTED[i].fixed) begin
        for (int k = 0; k < DIRECTED[i].cnt; k++)
          decoded_due.push_back('{DIRECTED[i].eb[k], DIRECTED[i].el[k]});
      end else begin
        foreach (beat_res[k]) decoded_due.push_back(beat_res[k]);
      end
    end

    // Strings of escapes and plain bytes, a few malformed or cut short.
    fed = 0;
    while (fed < RAND_ITEMS) begin
      feed_rush = ($urandom_range(0, 5) == 0);
      text.delete();
      chunks = $urandom_range(1, 6);
      for (int c = 0; c < chunks; c++) begin
        pick = $urandom_range(0, 9);
        unique case (pick)
          0, 1, 2, 3: begin
            text.push_back(PCT_CHAR);
            text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          end
          4, 5: text.push_back(8'($urandom_range(0, 255)));
          6: begin
            text.push_back(PCT_CHAR);
            if ($urandom_range(0, 1))
              text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            text.push_back(NEAR_HEX[4'($urandom_range(0, 12))]);
          end
          7: begin
            text.push_back(PCT_CHAR);
            if ($urandom_range(0, 1))
              text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          end
          default: text.push_back(8'($urandom_range(8'h20, 8'h7E)));
        endcase
      end
      for (int k = 0; k < text.size(); k++) begin
        send_beat(text[k], k == text.size() - 1);
        decode_beat(text[k], k == text.size() - 1);
        foreach (beat_res[j]) decoded_due.push_back(beat_res[j]);
        fed++;
      end
    end
    in_ch.in_valid <= 1'b0;

    while (decoded_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/upd_pkg.sv
hw/rtl/upd_stream_if.sv
hw/rtl/upd_step.sv
hw/rtl/url_percent_decoder.sv
tb/url_percent_decoder_tb.sv
